>>> hw/rtl/cdlf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package cdlf_pkg;

	// Configuration register indexes
	localparam logic [1:0] REG_CLICK_THRESHOLD = 2'd0;
	localparam logic [1:0] REG_PEAK_RATIO      = 2'd1;
	localparam logic [1:0] REG_MAX_RUN_LENGTH  = 2'd2;

	localparam int CFG_BITS     = 23;
	localparam int THR_BITS     = 23;
	localparam int RATIO_BITS   = 12;
	localparam int CAP_BITS     = 6;
	localparam int COUNT_BITS   = 16;
	localparam int LONGEST_BITS = 6;
	localparam int LEVEL_FLOOR  = 8;

	localparam logic [THR_BITS-1:0]   THR_RESET   = 23'd4194304;
	localparam logic [RATIO_BITS-1:0] RATIO_RESET = 12'd768;
	localparam logic [CAP_BITS-1:0]   CAP_RESET   = 6'd16;

	// How the front end classifies a word
	typedef enum logic [1:0] {
		KIND_START,
		KIND_MARK,
		KIND_PLAIN
	} kind_t;

	// Back end sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_CMP,
		ST_CMP2,
		ST_RD,
		ST_RDOUT,
		ST_DSTART,
		ST_DIV,
		ST_DIVOUT,
		ST_LAST
	} state_t;

endpackage
`default_nettype wire

>>> hw/rtl/cdlf_front.sv
`timescale 1ns / 1ps
`default_nettype none
module cdlf_front
	import cdlf_pkg::*;
#(
	parameter int SAMPLE_BITS = 24
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic [SAMPLE_BITS-1:0] in_sample,
	input  wire logic                   in_last,
	input  wire logic [THR_BITS-1:0]    click_threshold,
	output logic                        push,
	input  wire logic                   push_ready,
	output kind_t                       push_kind,
	output logic [SAMPLE_BITS-2:0]      push_mag
);

	localparam int MB = SAMPLE_BITS - 1;

	logic          at_start_q;
	logic [MB-1:0] mag;
	logic          is_min;

	// Magnitude, with the most negative code saturated to full scale.
	always_comb begin
		is_min = in_sample[SAMPLE_BITS-1] && (in_sample[MB-1:0] == '0);
		if (!in_sample[SAMPLE_BITS-1]) begin
			mag = in_sample[MB-1:0];
		end else if (is_min) begin
			mag = '1;
		end else begin
			mag = MB'(-in_sample);
		end
	end

	// Classification of the incoming word.
	always_comb begin
		in_ready = push_ready;
		push     = in_valid && push_ready;
		push_mag = mag;
		if (at_start_q) begin
			push_kind = KIND_START;
		end else if (!in_last && (32'(mag) >= 32'(click_threshold))) begin
			push_kind = KIND_MARK;
		end else begin
			push_kind = KIND_PLAIN;
		end
	end

	// Track start flag: set again after the final sample of a track.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			at_start_q <= 1'b1;
		end else if (push && (push_kind != KIND_MARK)) begin
			at_start_q <= in_last;
		end
	end

endmodule
`default_nettype wire

>>> hw/rtl/cdlf_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module cdlf_queue
	import cdlf_pkg::*;
#(
	parameter int WIDTH = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	output logic                  push_ready,
	input  wire logic [WIDTH-1:0] push_data,
	input  wire logic             pop,
	output logic                  pop_valid,
	output logic [WIDTH-1:0]      pop_data
);

	logic [WIDTH-1:0] slot_q [2];
	logic             wr_q;
	logic             rd_q;
	logic [1:0]       fill_q;

	assign push_ready = (fill_q != 2'd2);
	assign pop_valid  = (fill_q != 2'd0);
	assign pop_data   = slot_q[rd_q];

	// Two-entry ring between the front and back ends.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= 1'b0;
			rd_q   <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop && pop_valid) begin
				rd_q <= ~rd_q;
			end
			fill_q <= fill_q + 2'(push) - 2'(pop && pop_valid);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_data;
		end
	end

endmodule
`default_nettype wire

>>> hw/rtl/cdlf_back.sv
`timescale 1ns / 1ps
`default_nettype none
module cdlf_back
	import cdlf_pkg::*;
#(
	parameter int SAMPLE_BITS = 24,
	parameter int MAX_RUN     = 32
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   item_valid,
	output logic                        item_pop,
	input  wire logic [SAMPLE_BITS-1:0] item_sample,
	input  wire logic                   item_last,
	input  wire kind_t                  item_kind,
	input  wire logic [SAMPLE_BITS-2:0] item_mag,
	input  wire logic [RATIO_BITS-1:0]  peak_ratio,
	input  wire logic [CAP_BITS-1:0]    max_run_length,
	output logic                        o_valid,
	input  wire logic                   o_ready,
	output logic [SAMPLE_BITS-1:0]      o_sample,
	output logic                        o_repaired,
	output logic                        o_burst_last,
	output logic                        o_track_end,
	output logic [COUNT_BITS-1:0]       o_click_count,
	output logic [COUNT_BITS-1:0]       o_rejected_count,
	output logic [LONGEST_BITS-1:0]     o_longest_run
);

	localparam int SB = SAMPLE_BITS;
	localparam int MB = SB - 1;
	localparam int LW = $clog2(MAX_RUN + 1);
	localparam int AW = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;
	localparam int PW = MB + RATIO_BITS;
	localparam int NW = SB + 1 + LW;
	localparam int DW = NW + 1;
	localparam int CW = $clog2(DW + 1);
	localparam int VW = LW + 2;
	localparam int RW = LW + 3;

	state_t state_q, state_d;

	logic [SB-1:0]         x_q;
	logic                  last_q;
	kind_t                 kind_q;
	logic [MB-1:0]         mag_q;
	logic [LW-1:0]         len_q;
	logic [MB-1:0]         peak_q;
	logic [SB-1:0]         left_q;
	logic                  in_run_q;
	logic                  over_q;
	logic [COUNT_BITS-1:0] acc_q;
	logic [COUNT_BITS-1:0] rej_q;
	logic [LW-1:0]         long_q;
	logic [LW-1:0]         tot_q;
	logic [LW-1:0]         idx_q;
	logic [LW-1:0]         k_q;
	logic [MB-1:0]         level_q;
	logic [PW-1:0]         prod_q;
	logic signed [SB:0]    diff_q;
	logic signed [NW-1:0]  num_q;
	logic [RW-1:0]         rem_q;
	logic [DW-1:0]         quo_q;
	logic                  neg_q;
	logic [CW-1:0]         cnt_q;
	logic [SB-1:0]         rd_q;
	logic [SB-1:0]         run_mem [MAX_RUN];

	logic                  out_free;
	logic                  emit;
	logic [SB-1:0]         e_sample;
	logic                  e_rep;
	logic                  e_blast;
	logic                  e_end;
	logic [6:0]            cap;
	logic                  len_lt_cap;
	logic [MB-1:0]         left_mag;
	logic [MB-1:0]         lvl;
	logic                  accept;
	logic [NW-1:0]         abs_num;
	logic [DW-1:0]         dvd;
	logic [VW-1:0]         dvs;
	logic [RW-1:0]         rem_sh;
	logic signed [SB+1:0]  fill;

	// Effective cap, boundary level, acceptance test, divider operands and fill value.
	always_comb begin
		cap = ({1'b0, max_run_length} > 7'(MAX_RUN)) ? 7'(MAX_RUN) : {1'b0, max_run_length};
		len_lt_cap = 7'(len_q) < cap;
		if (!left_q[SB-1]) begin
			left_mag = left_q[MB-1:0];
		end else if (left_q[MB-1:0] == '0) begin
			left_mag = '1;
		end else begin
			left_mag = MB'(-left_q);
		end
		lvl = (left_mag > mag_q) ? left_mag : mag_q;
		if (32'(lvl) < 32'(LEVEL_FLOOR)) begin
			lvl = MB'(LEVEL_FLOOR);
		end
		accept = PW'({peak_q, 8'b0}) > prod_q;
		abs_num = num_q[NW-1] ? NW'(-num_q) : NW'(num_q);
		dvs = VW'({tot_q, 1'b0}) + VW'(2);
		dvd = DW'({abs_num, 1'b0}) + DW'(tot_q) + DW'(1);
		rem_sh = {rem_q[RW-2:0], quo_q[DW-1]};
		fill = (SB+2)'(signed'(left_q)) +
			(neg_q ? -(SB+2)'(quo_q[SB:0]) : (SB+2)'(quo_q[SB:0]));
	end

	// Next state and the word offered to the output register.
	always_comb begin
		out_free = !o_valid || o_ready;
		state_d  = state_q;
		item_pop = 1'b0;
		emit     = 1'b0;
		e_sample = x_q;
		e_rep    = 1'b0;
		e_blast  = 1'b0;
		e_end    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				item_pop = item_valid;
				if (item_valid) begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				case (kind_q)
					KIND_MARK: begin
						if (over_q) begin
							state_d = ST_LAST;
						end else if (len_lt_cap) begin
							state_d = ST_IDLE;
						end else begin
							state_d = (len_q != '0) ? ST_RD : ST_LAST;
						end
					end
					KIND_PLAIN: begin
						if (in_run_q && !over_q && (len_q != '0)) begin
							state_d = ST_CMP;
						end else begin
							state_d = ST_LAST;
						end
					end
					default: state_d = ST_LAST;
				endcase
			end
			ST_CMP:    state_d = ST_CMP2;
			ST_CMP2:   state_d = accept ? ST_DSTART : ST_RD;
			ST_RD:     state_d = ST_RDOUT;
			ST_RDOUT: begin
				e_sample = rd_q;
				if (out_free) begin
					emit    = 1'b1;
					state_d = (idx_q + LW'(1) == tot_q) ? ST_LAST : ST_RD;
				end
			end
			ST_DSTART: state_d = ST_DIV;
			ST_DIV: begin
				if (cnt_q == CW'(1)) begin
					state_d = ST_DIVOUT;
				end
			end
			ST_DIVOUT: begin
				e_sample = fill[SB-1:0];
				e_rep    = 1'b1;
				if (out_free) begin
					emit    = 1'b1;
					state_d = (k_q == tot_q) ? ST_LAST : ST_DSTART;
				end
			end
			ST_LAST: begin
				e_blast = 1'b1;
				e_end   = last_q;
				if (out_free) begin
					emit    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Run state and counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q    <= '0;
			peak_q   <= '0;
			left_q   <= '0;
			in_run_q <= 1'b0;
			over_q   <= 1'b0;
			acc_q    <= '0;
			rej_q    <= '0;
			long_q   <= '0;
		end else begin
			case (state_q)
				ST_DECIDE: begin
					case (kind_q)
						KIND_START: begin
							acc_q    <= '0;
							rej_q    <= '0;
							long_q   <= '0;
							len_q    <= '0;
							peak_q   <= '0;
							in_run_q <= 1'b0;
							over_q   <= 1'b0;
						end
						KIND_MARK: begin
							if (!over_q && len_lt_cap) begin
								len_q    <= len_q + LW'(1);
								in_run_q <= 1'b1;
								if (mag_q > peak_q) begin
									peak_q <= mag_q;
								end
							end else if (!over_q) begin
								len_q    <= '0;
								peak_q   <= '0;
								in_run_q <= 1'b1;
								over_q   <= 1'b1;
							end
						end
						default: begin
							if (in_run_q && over_q && (rej_q != '1)) begin
								rej_q <= rej_q + 1'b1;
							end
							if (!(in_run_q && !over_q && (len_q != '0))) begin
								len_q    <= '0;
								peak_q   <= '0;
								in_run_q <= 1'b0;
								over_q   <= 1'b0;
							end
						end
					endcase
				end
				ST_CMP2: begin
					if (accept) begin
						if (acc_q != '1) begin
							acc_q <= acc_q + 1'b1;
						end
						if (len_q > long_q) begin
							long_q <= len_q;
						end
					end else if (rej_q != '1) begin
						rej_q <= rej_q + 1'b1;
					end
					len_q    <= '0;
					peak_q   <= '0;
					in_run_q <= 1'b0;
					over_q   <= 1'b0;
				end
				ST_LAST: begin
					if (out_free && (kind_q != KIND_MARK)) begin
						left_q <= x_q;
					end
				end
				default: ;
			endcase
		end
	end

	// Working registers of the current word, replay and fill divider.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					x_q    <= item_sample;
					last_q <= item_last;
					kind_q <= item_kind;
					mag_q  <= item_mag;
				end
			end
			ST_DECIDE: begin
				level_q <= lvl;
				idx_q   <= '0;
				tot_q   <= len_q;
				if ((kind_q == KIND_MARK) && !over_q && len_lt_cap) begin
					run_mem[len_q[AW-1:0]] <= x_q;
				end
			end
			ST_CMP: prod_q <= PW'(level_q) * PW'(peak_ratio);
			ST_CMP2: begin
				idx_q  <= '0;
				tot_q  <= len_q;
				k_q    <= LW'(1);
				diff_q <= (SB+1)'(signed'(x_q)) - (SB+1)'(signed'(left_q));
				num_q  <= NW'((SB+1)'(signed'(x_q)) - (SB+1)'(signed'(left_q)));
			end
			ST_RD: rd_q <= run_mem[idx_q[AW-1:0]];
			ST_RDOUT: begin
				if (out_free) begin
					idx_q <= idx_q + LW'(1);
				end
			end
			ST_DSTART: begin
				quo_q <= dvd;
				rem_q <= '0;
				cnt_q <= CW'(DW);
				neg_q <= num_q[NW-1];
			end
			ST_DIV: begin
				cnt_q <= cnt_q - CW'(1);
				if (rem_sh >= RW'(dvs)) begin
					rem_q <= rem_sh - RW'(dvs);
					quo_q <= {quo_q[DW-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh;
					quo_q <= {quo_q[DW-2:0], 1'b0};
				end
			end
			ST_DIVOUT: begin
				if (out_free) begin
					k_q   <= k_q + LW'(1);
					num_q <= num_q + NW'(diff_q);
				end
			end
			default: ;
		endcase
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_valid <= 1'b0;
		end else if (emit) begin
			o_valid <= 1'b1;
		end else if (o_ready) begin
			o_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			o_sample         <= e_sample;
			o_repaired       <= e_rep;
			o_burst_last     <= e_blast;
			o_track_end      <= e_end;
			o_click_count    <= acc_q;
			o_rejected_count <= rej_q;
			o_longest_run    <= LONGEST_BITS'(long_q);
		end
	end

	a_over_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		over_q |-> in_run_q) else $error("over cap without an open run");
	a_idle_run_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!in_run_q |-> (len_q == '0) && (peak_q == '0)) else $error("stale run state");
	a_div_runs: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) && (cnt_q != CW'(1)) |=> (state_q == ST_DIV))
		else $error("divider left early");

endmodule
`default_nettype wire

>>> hw/rtl/click_detect_linear_fill.sv
// Click detector with linear fill for one audio track at a time.
// Input stream s_*: tdata carries a signed sample, tlast marks the track's final
// sample. Output stream m_*: every word carries a sample in input order, the
// running accepted and rejected run counts and the longest repaired run;
// tuser flags a repaired sample and the last word caused by an input, tlast
// marks the word that carries the track's final sample.
// Configuration is a write port (cfg_we, cfg_index, cfg_data), used while idle.
// Marked samples are buffered without output. An ordinary sample passes the
// back end's idle, decide and last states; a rejected or over-cap run is
// replayed from the run memory, a read and an output state a word; each repaired
// word takes the serial divider, with a SAMPLE_BITS + clog2(MAX_RUN+1) + 2 bit quotient.
// A two-word queue parts the front end from the back end, so up to two input
// words are taken while the back end works or the receiver stalls. A stall on
// m_tready holds the output register and the back end waits.
// Reset clears the run state and counters, restores register defaults and
// starts a new track; the run memory needs no clearing.
`timescale 1ns / 1ps
`default_nettype none
module click_detect_linear_fill
	import cdlf_pkg::*;
#(
	parameter int SAMPLE_BITS = 24,
	parameter int MAX_RUN     = 32
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	// in_sample
	input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
	input  wire logic                   s_tlast,
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	// out_sample, click_count, rejected_count, longest_run
	output logic [((SAMPLE_BITS+38+7)/8)*8-1:0] m_tdata,
	// repaired, burst_last
	output logic [1:0]                  m_tuser,
	output logic                        m_tlast,
	input  wire logic                   cfg_we,
	input  wire logic [1:0]             cfg_index,
	input  wire logic [CFG_BITS-1:0]    cfg_data
);

	localparam int SB = SAMPLE_BITS;
	localparam int MB = SB - 1;
	localparam int OB = SB + 2 * COUNT_BITS + LONGEST_BITS;
	localparam int OW = ((OB + 7) / 8) * 8;
	localparam int QW = SB + 1 + 2 + MB;

	logic [THR_BITS-1:0]   thr_q;
	logic [RATIO_BITS-1:0] ratio_q;
	logic [CAP_BITS-1:0]   cap_q;

	logic                  push;
	logic                  push_ready;
	kind_t                 push_kind;
	logic [MB-1:0]         push_mag;
	logic                  pop;
	logic                  pop_valid;
	logic [QW-1:0]         pop_data;
	logic [SB-1:0]         o_sample;
	logic [COUNT_BITS-1:0] o_click;
	logic [COUNT_BITS-1:0] o_rej;
	logic [LONGEST_BITS-1:0] o_long;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q   <= THR_RESET;
			ratio_q <= RATIO_RESET;
			cap_q   <= CAP_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CLICK_THRESHOLD: thr_q   <= cfg_data[THR_BITS-1:0];
				REG_PEAK_RATIO:      ratio_q <= cfg_data[RATIO_BITS-1:0];
				REG_MAX_RUN_LENGTH:  cap_q   <= cfg_data[CAP_BITS-1:0];
				default: ;
			endcase
		end
	end

	cdlf_front #(.SAMPLE_BITS(SB)) u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (s_tvalid),
		.in_ready        (s_tready),
		.in_sample       (s_tdata[SB-1:0]),
		.in_last         (s_tlast),
		.click_threshold (thr_q),
		.push            (push),
		.push_ready      (push_ready),
		.push_kind       (push_kind),
		.push_mag        (push_mag)
	);

	cdlf_queue #(.WIDTH(QW)) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_ready (push_ready),
		.push_data  ({push_mag, push_kind, s_tlast, s_tdata[SB-1:0]}),
		.pop        (pop),
		.pop_valid  (pop_valid),
		.pop_data   (pop_data)
	);

	cdlf_back #(.SAMPLE_BITS(SB), .MAX_RUN(MAX_RUN)) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.item_valid       (pop_valid),
		.item_pop         (pop),
		.item_sample      (pop_data[SB-1:0]),
		.item_last        (pop_data[SB]),
		.item_kind        (kind_t'(pop_data[SB+2:SB+1])),
		.item_mag         (pop_data[QW-1:SB+3]),
		.peak_ratio       (ratio_q),
		.max_run_length   (cap_q),
		.o_valid          (m_tvalid),
		.o_ready          (m_tready),
		.o_sample         (o_sample),
		.o_repaired       (m_tuser[0]),
		.o_burst_last     (m_tuser[1]),
		.o_track_end      (m_tlast),
		.o_click_count    (o_click),
		.o_rejected_count (o_rej),
		.o_longest_run    (o_long)
	);

	assign m_tdata = OW'({o_long, o_rej, o_click, o_sample});

endmodule
`default_nettype wire
